FILE: rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

	// Field and register widths
	localparam int unsigned GapW      = 24;
	localparam int unsigned PulseW    = 8;
	localparam int unsigned EchoW     = 20;
	localparam int unsigned SpeedW    = 16;
	localparam int unsigned RangeW    = 16;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 24;

	// Distance = echo time * speed >> RangeShift
	localparam int unsigned RangeShift = 17;
	localparam int unsigned ProdW      = EchoW + SpeedW;

	localparam logic [RangeW-1:0] TimeoutRange = RangeW'(3000);

	// Register indexes on the configuration port
	typedef enum logic [CfgIndexW-1:0] {
		CFG_MEASURE_GAP   = 2'd0,
		CFG_TRIGGER_PULSE = 2'd1,
		CFG_ECHO_TIMEOUT  = 2'd2,
		CFG_SPEED_FACTOR  = 2'd3
	} cfg_index_t;

	// Configuration register set
	typedef struct packed {
		logic [GapW-1:0]   measure_gap_us;
		logic [PulseW-1:0] trigger_pulse_us;
		logic [EchoW-1:0]  echo_timeout_us;
		logic [SpeedW-1:0] speed_factor_q16;
	} cfg_t;

	// One input item (one microsecond tick)
	typedef struct packed {
		logic echo_level;
		logic enable_level;
		logic read_ack;
	} item_t;

	// One result item
	typedef struct packed {
		logic              trigger_level;
		logic [RangeW-1:0] distance;
		logic              new_distance;
		logic              timed_out;
		logic              measuring;
		logic              ranging_active;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/uer_cfg_regs.sv
`default_nettype none

module uer_cfg_regs
	import uer_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CfgIndexW-1:0] wr_index,
	input  wire logic [CfgDataW-1:0]  wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Register file, reset to the power-on ranging defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure_gap_us   <= GapW'(60000);
			cfg_q.trigger_pulse_us <= PulseW'(10);
			cfg_q.echo_timeout_us  <= EchoW'(30000);
			cfg_q.speed_factor_q16 <= SpeedW'(22479);
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_MEASURE_GAP:   cfg_q.measure_gap_us   <= wr_data[GapW-1:0];
				CFG_TRIGGER_PULSE: cfg_q.trigger_pulse_us <= wr_data[PulseW-1:0];
				CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout_us  <= wr_data[EchoW-1:0];
				CFG_SPEED_FACTOR:  cfg_q.speed_factor_q16 <= wr_data[SpeedW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/uer_engine.sv
`default_nettype none

module uer_engine
	import uer_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step_en,
	input  wire cfg_t    cfg,
	input  wire item_t   item,
	output result_t      result
);

	// Ranging state
	logic              active_q, prev_enable_q, trigger_high_q, listening_q, awaiting_fall_q;
	logic              fresh_q, timeout_q;
	logic [GapW-1:0]   gap_timer_q;
	logic [PulseW-1:0] pulse_timer_q;
	logic [EchoW-1:0]  echo_timer_q;
	logic [RangeW-1:0] range_q;

	logic              active_d, trigger_high_d, listening_d, awaiting_fall_d;
	logic              fresh_d, timeout_d;
	logic [GapW-1:0]   gap_inc, gap_timer_d;
	logic [PulseW-1:0] pulse_inc, pulse_timer_d;
	logic [EchoW-1:0]  echo_inc, echo_timer_d;
	logic [RangeW-1:0] range_d;
	logic [ProdW-1:0]  product;
	logic [ProdW-RangeShift-1:0] scaled;
	logic [RangeW-1:0] range_calc;

	// Saturating microsecond timers
	assign gap_inc   = (&gap_timer_q)   ? gap_timer_q   : gap_timer_q + GapW'(1);
	assign pulse_inc = (&pulse_timer_q) ? pulse_timer_q : pulse_timer_q + PulseW'(1);
	assign echo_inc  = (&echo_timer_q)  ? echo_timer_q  : echo_timer_q + EchoW'(1);

	// Distance from the echo width, saturated to the field range
	assign product    = ProdW'(echo_inc) * ProdW'(cfg.speed_factor_q16);
	assign scaled     = product[ProdW-1:RangeShift];
	assign range_calc = (|scaled[ProdW-RangeShift-1:RangeW]) ? {RangeW{1'b1}}
		: scaled[RangeW-1:0];

	// Next state for one tick
	always_comb begin
		gap_timer_d     = gap_inc;
		pulse_timer_d   = pulse_inc;
		echo_timer_d    = echo_inc;
		active_d        = active_q;
		trigger_high_d  = trigger_high_q;
		listening_d     = listening_q;
		awaiting_fall_d = awaiting_fall_q;
		fresh_d         = fresh_q;
		timeout_d       = timeout_q;
		range_d         = range_q;

		// enable edges
		if (item.enable_level && !prev_enable_q) begin
			active_d = 1'b1;
		end else if (!item.enable_level && prev_enable_q) begin
			active_d        = 1'b0;
			listening_d     = 1'b0;
			awaiting_fall_d = 1'b0;
			fresh_d         = 1'b0;
			timeout_d       = 1'b0;
		end

		if (item.read_ack) begin
			fresh_d = 1'b0;
		end

		if (listening_d) begin
			// echo timing
			if (item.echo_level) begin
				if (!awaiting_fall_d) begin
					echo_timer_d    = '0;
					awaiting_fall_d = 1'b1;
				end
			end else if (awaiting_fall_d) begin
				range_d         = range_calc;
				fresh_d         = 1'b1;
				listening_d     = 1'b0;
				awaiting_fall_d = 1'b0;
				timeout_d       = 1'b0;
			end else if (echo_inc > cfg.echo_timeout_us) begin
				listening_d     = 1'b0;
				awaiting_fall_d = 1'b0;
				range_d         = TimeoutRange;
				active_d        = 1'b1;
				fresh_d         = 1'b0;
				timeout_d       = 1'b1;
			end
		end else if (active_d && (gap_inc > cfg.measure_gap_us)) begin
			// trigger pulse
			if (trigger_high_q) begin
				if (pulse_inc > cfg.trigger_pulse_us) begin
					trigger_high_d = 1'b0;
					gap_timer_d    = '0;
					echo_timer_d   = '0;
					listening_d    = 1'b1;
				end
			end else begin
				trigger_high_d = 1'b1;
				pulse_timer_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			prev_enable_q   <= 1'b0;
			trigger_high_q  <= 1'b0;
			listening_q     <= 1'b0;
			awaiting_fall_q <= 1'b0;
			fresh_q         <= 1'b0;
			timeout_q       <= 1'b0;
			gap_timer_q     <= '0;
			pulse_timer_q   <= '0;
			echo_timer_q    <= '0;
			range_q         <= '0;
		end else if (step_en) begin
			active_q        <= active_d;
			prev_enable_q   <= item.enable_level;
			trigger_high_q  <= trigger_high_d;
			listening_q     <= listening_d;
			awaiting_fall_q <= awaiting_fall_d;
			fresh_q         <= fresh_d;
			timeout_q       <= timeout_d;
			gap_timer_q     <= gap_timer_d;
			pulse_timer_q   <= pulse_timer_d;
			echo_timer_q    <= echo_timer_d;
			range_q         <= range_d;
		end
	end

	// Result reflects the state after this tick
	always_comb begin
		result.trigger_level  = trigger_high_d;
		result.distance       = range_d;
		result.new_distance   = fresh_d;
		result.timed_out      = timeout_d;
		result.measuring      = listening_d;
		result.ranging_active = active_d;
	end

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger_top.sv
`default_nettype none

// Ultrasonic time-of-flight ranger. Each input item is one microsecond tick
// carrying the sampled echo pin, the enable level and a read acknowledge;
// each tick yields exactly one result item with the trigger pin level, the
// last distance (echo width times speed_factor_q16 >> 17, saturating at
// 65535, or 3000 after a timeout) and the status flags. The block takes one
// item per clock cycle while in_stall is low; a result is offered once its item
// has passed the input register and then the result register, which sit around
// the combinational state update with its 20x16 multiplier. A stalled result holds
// the item behind it, so the input stalls only while both registers are full.
// Configuration is written through the cfg port at any time, always ready,
// but should only change while no tick is in flight.
module ultrasonic_echo_ranger_top
	import uer_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// tick input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 echo_level,
	input  wire logic                 enable_level,
	input  wire logic                 read_ack,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      trigger_level,
	output logic [RangeW-1:0]         distance,
	output logic                      new_distance,
	output logic                      timed_out,
	output logic                      measuring,
	output logic                      ranging_active,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    accept;

	assign cfg_ready = 1'b1;

	uer_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Item moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.echo_level   <= echo_level;
			item_s1.enable_level <= enable_level;
			item_s1.read_ack     <= read_ack;
		end
	end

	uer_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cfg     (cfg),
		.item    (item_s1),
		.result  (step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign trigger_level  = res_q.trigger_level;
	assign distance       = res_q.distance;
	assign new_distance   = res_q.new_distance;
	assign timed_out      = res_q.timed_out;
	assign measuring      = res_q.measuring;
	assign ranging_active = res_q.ranging_active;

`ifndef SYNTHESIS
	// trigger is always low while listening
	a_trig_not_listening: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.trigger_level && res_q.measuring))
		else $error("trigger high while measuring");

	// a fresh distance and a timeout never coexist
	a_fresh_xor_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.new_distance && res_q.timed_out))
		else $error("new_distance and timed_out both set");

	// listening only happens while enabled
	a_measuring_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.measuring |-> res_q.ranging_active)
		else $error("measuring while ranging inactive");

	// input only stalls when the input register holds a waiting item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked item");
`endif

endmodule

`default_nettype wire
